### hw/rtl/cycle_count_timestamp_top_defines.svh
// Assertion macros used by the timestamp back end
`ifndef CYCLE_COUNT_TIMESTAMP_TOP_DEFINES_SVH
`define CYCLE_COUNT_TIMESTAMP_TOP_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define CCT_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence on the next edge
`define CCT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/cct_pkg.sv
// Shared types and constants for the cycle-count timestamp block
`default_nettype none
package cct_pkg;
    localparam logic [9:0] MsPerS = 10'd1000;
    localparam logic [19:0] UsPerS = 20'd1000000;
    localparam logic [29:0] NsPerS = 30'd1000000000;
    // floor(x / 1000) = (x * MsRecip) >> 38 for any 32-bit x
    localparam logic [28:0] MsRecip = 29'd274877907;
    // floor(x / 1000000) = (x * UsRecip) >> 50 for any 32-bit x
    localparam logic [30:0] UsRecip = 31'd1125899907;

    typedef struct packed {
        logic [31:0] counter_value;
        logic [31:0] reference_count;
    } cct_in_t;

    typedef struct packed {
        logic [63:0] whole_seconds;
        logic [9:0]  milliseconds_part;
        logic [10:0] microseconds_part;
        logic [63:0] total_microseconds;
        logic [63:0] total_nanoseconds;
        logic [31:0] elapsed_cycles;
    } cct_out_t;

    // job passed from the front to the back
    typedef struct packed {
        logic [63:0] total;
        logic [31:0] elapsed;
    } cct_job_t;
endpackage
`default_nettype wire

### hw/rtl/cycle_count_timestamp_top.sv
// Top level of the cycle-count timestamp block
//  channel | direction | handshake
//  cfg     | in        | cfg_valid / cfg_ready, 32-bit frequency
//  in      | in        | in_valid / in_ready, cct_in_t
//  out     | out       | out_valid / out_ready, cct_out_t
// An item passes from input transfer to result valid through the front register,
// reciprocal multiplies for the divisors, four serial 96-step divisions in one
// shared radix-2 divider, and four multiply steps.
// Reset clears wrap state and sets the frequency to 100 MHz.
// One job waits in the front stage while the back works; the result register
// holds under output stall while the next job proceeds.
`default_nettype none
module cycle_count_timestamp_top
    import cct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cct_in_t     in_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    output cct_out_t         out_data,
    output logic             out_valid,
    input  wire logic        out_ready
);
    logic [31:0] freq_reg;
    cct_job_t    job;
    logic        job_valid;
    logic        job_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= 32'd100000000;
        end
        else if (cfg_valid)
        begin
            freq_reg <= cfg_data;
        end
    end

    cct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    cct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .freq      (freq_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );
endmodule
`default_nettype wire

### hw/rtl/cct_front.sv
// Front end: wrap tracking and extended count formation
`default_nettype none
module cct_front
    import cct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cct_in_t  in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output cct_job_t      job,
    output logic          job_valid,
    input  wire logic     job_ready
);
    logic [31:0] prev_reg;
    logic [63:0] wrap_reg;
    logic [63:0] wrap_next;
    logic        full_reg;
    cct_job_t    job_reg;

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;
    assign wrap_next = (in_data.counter_value < prev_reg) ? wrap_reg + 64'd1 : wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            wrap_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                prev_reg <= in_data.counter_value;
                wrap_reg <= wrap_next;
                full_reg <= 1'b1;
            end
            else if (job_ready)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg.total   <= {wrap_next[31:0], in_data.counter_value};
            job_reg.elapsed <= in_data.counter_value - in_data.reference_count;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/cct_div.sv
// Restoring radix-2 divider, 96-bit dividend by 64-bit divisor
`default_nettype none
module cct_div
    import cct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [95:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [95:0]      quo,
    output logic [63:0]      rem
);
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [95:0] q_reg;
    logic [64:0] r_reg;
    logic [63:0] d_reg;
    logic [64:0] sh;
    logic [64:0] diff;

    assign sh   = {r_reg[63:0], q_reg[95]};
    assign diff = sh - {1'b0, d_reg};
    assign quo  = q_reg;
    assign rem  = r_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd96;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[94:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[94:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/cct_back.sv
// Back end: divisions, scaling and result register
`default_nettype none
module cct_back
    import cct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] freq,
    input  wire cct_job_t    job,
    input  wire logic        job_valid,
    output logic             job_ready,
    output cct_out_t         out_data,
    output logic             out_valid,
    input  wire logic        out_ready
);
    `include "cycle_count_timestamp_top_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_PMS, S_PUS, S_SEC, S_MS, S_US, S_NSM, S_NS, S_MUL, S_OUT
    } state_t;

    state_t      state_reg;
    logic        start_reg;
    logic        start_next;
    logic [95:0] num_reg;
    logic [63:0] den_reg;
    logic        done;
    logic [95:0] quo;
    logic [63:0] rem;
    logic [31:0] pms_reg;
    logic [31:0] pus_reg;
    logic [63:0] secs_reg;
    logic [63:0] rems_reg;
    logic [63:0] remms_reg;
    logic [9:0]  ms_reg;
    logic [10:0] us_reg;
    logic [63:0] frac_reg;
    logic [31:0] el_reg;
    logic [63:0] total_reg;
    logic [1:0]  mstep_reg;
    logic [63:0] acc_us_reg;
    logic [63:0] acc_ns_reg;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [60:0] pms_prod;
    logic [62:0] pus_prod;
    logic [61:0] nsm_prod;
    cct_out_t    out_reg;
    logic        ov_reg;

    // zero divisor: all-ones quotient, dividend as remainder
    function automatic logic [63:0] zq(input logic [63:0] d, input logic [95:0] q);
        return (d == '0) ? '1 : q[63:0];
    endfunction

    cct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (done),
        .quo   (quo),
        .rem   (rem)
    );

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    assign pms_prod = {29'd0, freq} * {32'd0, MsRecip};
    assign pus_prod = {31'd0, freq} * {32'd0, UsRecip};
    assign nsm_prod = {30'd0, rems_reg[31:0]} * {32'd0, NsPerS};

    always_comb
    begin
        case (state_reg)
            S_PUS:   start_next = 1'b1;
            S_SEC:   start_next = done;
            S_MS:    start_next = done;
            S_NSM:   start_next = 1'b1;
            default: start_next = 1'b0;
        endcase
    end

    always_comb
    begin
        case (mstep_reg)
            2'd0:    mul_a = secs_reg[31:0];
            2'd1:    mul_a = secs_reg[63:32];
            2'd2:    mul_a = secs_reg[31:0];
            default: mul_a = secs_reg[63:32];
        endcase
    end
    assign mul_p = {32'd0, mul_a} * (mstep_reg[1] ? {34'd0, NsPerS} : {44'd0, UsPerS});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
            ov_reg    <= 1'b0;
            mstep_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            if (ov_reg && out_ready && (state_reg != S_OUT))
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        total_reg <= job.total;
                        el_reg    <= job.elapsed;
                        state_reg <= S_PMS;
                    end
                end
                S_PMS:
                begin
                    pms_reg   <= {9'd0, pms_prod[60:38]};
                    state_reg <= S_PUS;
                end
                S_PUS:
                begin
                    pus_reg   <= {19'd0, pus_prod[62:50]};
                    num_reg   <= {32'd0, total_reg};
                    den_reg   <= {32'd0, freq};
                    state_reg <= S_SEC;
                end
                S_SEC:
                begin
                    if (done)
                    begin
                        secs_reg  <= zq(den_reg, quo);
                        rems_reg  <= (den_reg == '0) ? total_reg : rem;
                        num_reg   <= {32'd0, ((den_reg == '0) ? total_reg : rem)};
                        den_reg   <= {32'd0, pms_reg};
                        state_reg <= S_MS;
                    end
                end
                S_MS:
                begin
                    if (done)
                    begin
                        ms_reg    <= (den_reg == '0) ? 10'h3FF : quo[9:0];
                        remms_reg <= (den_reg == '0) ? rems_reg : rem;
                        num_reg   <= {32'd0, ((den_reg == '0) ? rems_reg : rem)};
                        den_reg   <= {32'd0, pus_reg};
                        state_reg <= S_US;
                    end
                end
                S_US:
                begin
                    if (done)
                    begin
                        us_reg    <= (den_reg == '0) ? 11'h7FF : quo[10:0];
                        num_reg   <= {34'd0, nsm_prod};
                        state_reg <= S_NSM;
                    end
                end
                S_NSM:
                begin
                    den_reg   <= {32'd0, freq};
                    state_reg <= S_NS;
                end
                S_NS:
                begin
                    if (done)
                    begin
                        frac_reg   <= (den_reg == '0) ? '1 : quo[63:0];
                        mstep_reg  <= '0;
                        acc_us_reg <= {54'd0, ms_reg} * {54'd0, MsPerS} + {53'd0, us_reg};
                        acc_ns_reg <= '0;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 2'd1;
                    case (mstep_reg)
                        2'd0:    acc_us_reg <= acc_us_reg + mul_p;
                        2'd1:    acc_us_reg <= acc_us_reg + {mul_p[31:0], 32'd0};
                        2'd2:    acc_ns_reg <= frac_reg + mul_p;
                        default: acc_ns_reg <= acc_ns_reg + {mul_p[31:0], 32'd0};
                    endcase
                    if (mstep_reg == 2'd3)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        out_reg.whole_seconds      <= secs_reg;
                        out_reg.milliseconds_part  <= ms_reg;
                        out_reg.microseconds_part  <= us_reg;
                        out_reg.total_microseconds <= acc_us_reg;
                        out_reg.total_nanoseconds  <= acc_ns_reg;
                        out_reg.elapsed_cycles     <= el_reg;
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CCT_ASSERT_IMPLY(a_take, clk, rst_n, job_valid && job_ready, state_reg == S_IDLE, "bad take")
    `CCT_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg, "result dropped")
    `CCT_ASSERT_NEXT(a_start_div, clk, rst_n, state_reg == S_NSM, start_reg, "no ns start")
endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for the cycle-count timestamp block: directed table plus random samples
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import cct_pkg::*;

    typedef struct {
        logic [31:0] counter_value;
        logic [31:0] reference_count;
        logic        known;
        cct_out_t    result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic [31:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cct_in_t     in_data;
    logic        in_valid;
    logic        in_ready;
    cct_out_t    out_data;
    logic        out_valid;
    logic        out_ready;

    logic [31:0] model_freq;
    logic [31:0] model_prev;
    logic [63:0] model_wraps;
    cct_out_t    expected_q[$];
    int          mismatches;
    stim_row_t   directed[$];

    cycle_count_timestamp_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #500ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] div_q(input logic [63:0] n, input logic [63:0] d);
        return (d == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : n / d;
    endfunction

    function automatic logic [63:0] div_r(input logic [63:0] n, input logic [63:0] d);
        return (d == 0) ? n : n % d;
    endfunction

    function automatic cct_out_t timestamp_of(input logic [31:0] sample,
                                              input logic [31:0] reference);
        cct_out_t    r;
        logic [63:0] f, per_ms, per_us, total, secs, rem_s, rem_ms, ms, us;
        f = {32'd0, model_freq};
        per_ms = f / 1000;
        per_us = f / 1000000;
        if (sample < model_prev)
            model_wraps = model_wraps + 1;
        model_prev = sample;
        total = (model_wraps << 32) + {32'd0, sample};
        secs = div_q(total, f);
        rem_s = div_r(total, f);
        ms = div_q(rem_s, per_ms) & 64'h3FF;
        rem_ms = div_r(rem_s, per_ms);
        us = div_q(rem_ms, per_us) & 64'h7FF;
        r.whole_seconds = secs;
        r.milliseconds_part = ms[9:0];
        r.microseconds_part = us[10:0];
        r.total_microseconds = secs * 64'd1000000 + ms * 64'd1000 + us;
        r.total_nanoseconds = secs * 64'd1000000000 + div_q(rem_s * 64'd1000000000, f);
        r.elapsed_cycles = sample - reference;
        return r;
    endfunction

    task automatic write_frequency(input logic [31:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        model_freq = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] sample, input logic [31:0] reference,
                               input logic known, input cct_out_t typed);
        cct_out_t e;
        int       gap;
        gap = $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= '{counter_value: sample, reference_count: reference};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        e = timestamp_of(sample, reference);
        expected_q.push_back(known ? typed : e);
    endtask

    function automatic stim_row_t row(input logic [31:0] s, input logic [31:0] r);
        stim_row_t x;
        x.counter_value = s;
        x.reference_count = r;
        x.known = 1'b0;
        x.result = '0;
        return x;
    endfunction

    initial
    begin
        stim_row_t   x;
        logic [31:0] s;
        int          phase;
        logic [31:0] freqs[5] = '{32'd100000000, 32'd1000000, 32'hFFFF_FFFF,
                                  32'd1000999, 32'd48000000};
        rst_n = 1'b0;
        cfg_data = '0;
        cfg_valid = 1'b0;
        in_data = '0;
        in_valid = 1'b0;
        mismatches = 0;
        model_freq = 32'd100000000;
        model_prev = '0;
        model_wraps = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        x = row(32'd0, 32'd0);
        x.known = 1'b1;
        directed.push_back(x);
        x = row(32'd100000000, 32'd1);
        x.known = 1'b1;
        x.result = '{64'd1, 10'd0, 11'd0, 64'd1000000, 64'd1000000000, 32'd99999999};
        directed.push_back(x);
        directed.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(row(32'd5, 32'hFFFF_FFFF));
        directed.push_back(row(32'd5, 32'd6));
        directed.push_back(row(32'd4, 32'd0));
        directed.push_back(row(32'h8000_0000, 32'h7FFF_FFFF));
        directed.push_back(row(32'h5555_5555, 32'hAAAA_AAAA));
        directed.push_back(row(32'hAAAA_AAAA, 32'h5555_5555));
        directed.push_back(row(32'd123456789, 32'd0));
        foreach (directed[i])
            send_sample(directed[i].counter_value, directed[i].reference_count,
                        directed[i].known, directed[i].result);

        for (phase = 0; phase < 5; phase++)
        begin
            write_frequency(freqs[phase]);
            for (int i = 0; i < 160; i++)
            begin
                case ($urandom_range(0, 3))
                    0: s = $urandom();
                    1: s = model_prev + $urandom_range(0, 100000000);
                    2: s = model_prev - $urandom_range(1, 1000);
                    default: s = (i % 2) ? 32'hFFFF_FFFF : 32'd0;
                endcase
                send_sample(s, $urandom(), 1'b0, '0);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 6);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cct_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %p", out_data);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, out_data);
                end
            end
        end
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/cct_pkg.sv
hw/rtl/cct_front.sv
hw/rtl/cct_div.sv
hw/rtl/cct_back.sv
hw/rtl/cycle_count_timestamp_top.sv
dv/testbench.sv
